@@ rtl/core/mbd_pkg.sv @@
package mbd_pkg;

  localparam int CHAN_W            = 8;
  localparam int SUM_W             = CHAN_W + 1;
  localparam int LINE_W            = 3 * SUM_W;
  localparam int LOG2_W            = 4;
  localparam int LOG2_LIMIT        = 11;
  localparam int CNT_W             = LOG2_LIMIT;
  localparam int SLOT_W            = CNT_W - 1;
  localparam int DEFAULT_MAX_WIDTH = 2048;
  localparam int CFG_INDEX_W       = 1;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_WIDTH_LOG2  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT_LOG2 = 1'b1;

  typedef enum logic [1:0] {
    MODE_PASS  = 2'd0,   // 1x1 source
    MODE_VPAIR = 2'd1,   // one pixel wide
    MODE_HPAIR = 2'd2,   // one row high
    MODE_QUAD  = 2'd3    // full 2x2 box
  } mode_t;

  typedef struct packed {
    mode_t             mode;
    logic              emit;     // this item yields an output pixel
    logic              hold;     // capture pixel into held register
    logic              line_wr;  // write pair sum to line store
    logic              last;
    logic [SLOT_W-1:0] slot;
  } ctrl_t;

endpackage

@@ rtl/core/mipmap_box_downsample_top.sv @@
// Path: the item that completes a pixel is registered into stage A, then into the output
// register, where out_valid rises; a stalled output can hold the pixel in stage A.
// Throughput: one source item per cycle unless stalled; one output pixel per 4, 2 or 1 items
// by image shape. Line store: one address per item, written on even rows, read on every item.
// Reset (rst, synchronous): clears counters, size registers, held pixel and pipeline valids.
// Line store is never cleared: each entry is used only after this frame's even row wrote it.
module mipmap_box_downsample_top
  import mbd_pkg::*;
#(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration write port
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LOG2_W-1:0]      cfg_data,
  // source pixel channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [CHAN_W-1:0]      red_in,
  input  logic [CHAN_W-1:0]      green_in,
  input  logic [CHAN_W-1:0]      blue_in,
  // output pixel channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [CHAN_W-1:0]      red_out,
  output logic [CHAN_W-1:0]      green_out,
  output logic [CHAN_W-1:0]      blue_out,
  output logic                   last_pixel
);

  // One line entry per output column.
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  ctrl_t ctrl;
  logic  accept;

  // Stage A: pair sums plus the line word read alongside them.
  logic              a_valid;
  logic              a_quad;
  logic              a_last;
  logic [LINE_W-1:0] a_sums;
  logic [LINE_W-1:0] above;
  logic              b_load;

  logic [3*CHAN_W-1:0] held_pixel;
  logic [3*CHAN_W-1:0] pix;
  logic [LINE_W-1:0]   sums;
  logic [SLOT_W+AW-1:0] slot_ext;
  logic [AW-1:0]        line_addr;

  // Stage A moves on when the output register is empty or being taken.
  assign b_load   = a_valid && (!out_valid || !out_stall);
  assign in_stall = a_valid && !b_load;
  assign accept   = in_valid && !in_stall;

  assign pix = {blue_in, green_in, red_in};

  // Horizontal pair sum per channel; a 1x1 source doubles its own pixel so
  // the pair average passes it through unchanged.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [CHAN_W-1:0] first;
      first = (ctrl.mode == MODE_PASS) ? pix[c*CHAN_W +: CHAN_W]
                                       : held_pixel[c*CHAN_W +: CHAN_W];
      sums[c*SUM_W +: SUM_W] = SUM_W'(first) + SUM_W'(pix[c*CHAN_W +: CHAN_W]);
    end
  end

  // Slot is always below the line depth; fit it to the address width.
  assign slot_ext  = {{AW{1'b0}}, ctrl.slot};
  assign line_addr = slot_ext[AW-1:0];

  mbd_frame_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_frame_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (accept),
    .ctrl      (ctrl)
  );

  mbd_line_store #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (accept && ctrl.line_wr),
    .rd_en   (accept),
    .addr    (line_addr),
    .wr_data (sums),
    .rd_data (above)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_pixel <= '0;
      a_valid    <= 1'b0;
    end else begin
      if (accept && ctrl.hold) begin
        held_pixel <= pix;
      end
      if (accept) begin
        a_valid <= ctrl.emit;
      end else if (b_load) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_quad <= (ctrl.mode == MODE_QUAD);
      a_last <= ctrl.last;
      a_sums <= sums;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  mbd_average u_average (
    .clk        (clk),
    .load       (b_load),
    .quad       (a_quad),
    .last_in    (a_last),
    .sums       (a_sums),
    .above      (above),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .last_pixel (last_pixel)
  );

  // input backs up only behind an occupied stage A
  assert property (@(posedge clk) disable iff (rst) in_stall |-> a_valid)
    else $error("input stalled with stage A empty");

  // an item that completes a pixel lands in stage A
  assert property (@(posedge clk) disable iff (rst) accept && ctrl.emit |=> a_valid)
    else $error("result item lost entering stage A");

  // a held stage A keeps its sums for the next transfer
  assert property (@(posedge clk) disable iff (rst)
    a_valid && !b_load |=> a_valid && $stable(a_sums) && $stable(above))
    else $error("stage A changed while blocked");

  // a taken output with nothing behind it leaves the output empty
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !a_valid |=> !out_valid)
    else $error("output repeated");

endmodule

@@ rtl/core/mbd_frame_ctrl.sv @@
module mbd_frame_ctrl
  import mbd_pkg::*;
#(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LOG2_W-1:0]      cfg_data,
  input  logic                   advance,
  output ctrl_t                  ctrl
);

  // floor(log2(MAX_WIDTH)), capped at the register limit
  localparam int FLOOR_LOG2 = $clog2(MAX_WIDTH + 1) - 1;
  localparam int WLOG_MAX   = (FLOOR_LOG2 > LOG2_LIMIT) ? LOG2_LIMIT : FLOOR_LOG2;

  logic [LOG2_W-1:0] width_log2;
  logic [LOG2_W-1:0] height_log2;
  logic [CNT_W-1:0]  column_count;
  logic [CNT_W-1:0]  row_count;
  logic [CNT_W-1:0]  column_count_next;
  logic [CNT_W-1:0]  row_count_next;

  logic [LOG2_W-1:0] wl;
  logic [LOG2_W-1:0] hl;
  logic [CNT_W:0]    w_full;
  logic [CNT_W:0]    h_full;
  logic [CNT_W:0]    w_mask;
  logic [CNT_W:0]    h_mask;
  logic              col_end;
  logic              row_end;
  logic              col_odd;
  logic              row_odd;

  always_comb begin
    wl      = (width_log2 > LOG2_W'(WLOG_MAX)) ? LOG2_W'(WLOG_MAX) : width_log2;
    hl      = (height_log2 > LOG2_W'(LOG2_LIMIT)) ? LOG2_W'(LOG2_LIMIT) : height_log2;
    w_full  = (CNT_W + 1)'(1) << wl;
    h_full  = (CNT_W + 1)'(1) << hl;
    w_mask  = w_full - (CNT_W + 1)'(1);
    h_mask  = h_full - (CNT_W + 1)'(1);
    col_end = (column_count == w_mask[CNT_W-1:0]);
    row_end = (row_count == h_mask[CNT_W-1:0]);
    col_odd = column_count[0];
    row_odd = row_count[0];

    if (wl == '0 && hl == '0) begin
      ctrl.mode = MODE_PASS;
    end else if (wl == '0) begin
      ctrl.mode = MODE_VPAIR;
    end else if (hl == '0) begin
      ctrl.mode = MODE_HPAIR;
    end else begin
      ctrl.mode = MODE_QUAD;
    end

    case (ctrl.mode)
      MODE_PASS: begin
        ctrl.emit = 1'b1;
        ctrl.hold = 1'b0;
      end
      MODE_VPAIR: begin
        ctrl.emit = row_odd;
        ctrl.hold = !row_odd;
      end
      MODE_HPAIR: begin
        ctrl.emit = col_odd;
        ctrl.hold = !col_odd;
      end
      default: begin
        ctrl.emit = col_odd && row_odd;
        ctrl.hold = !col_odd;
      end
    endcase
    ctrl.line_wr = (ctrl.mode == MODE_QUAD) && col_odd && !row_odd;
    ctrl.last    = col_end && row_end;
    ctrl.slot    = column_count[CNT_W-1:1];

    if (col_end) begin
      column_count_next = '0;
      row_count_next    = row_end ? '0 : row_count + CNT_W'(1);
    end else begin
      column_count_next = column_count + CNT_W'(1);
      row_count_next    = row_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_log2   <= '0;
      height_log2  <= '0;
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIDTH_LOG2:  width_log2  <= cfg_data;
        REG_HEIGHT_LOG2: height_log2 <= cfg_data;
        default: ;
      endcase
      column_count <= '0;
      row_count    <= '0;
    end else if (advance) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

@@ rtl/core/mbd_line_store.sv @@
module mbd_line_store
  import mbd_pkg::*;
#(
  parameter int DEPTH = DEFAULT_MAX_WIDTH / 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic              rd_en,
  input  logic [AW-1:0]     addr,
  input  logic [LINE_W-1:0] wr_data,
  output logic [LINE_W-1:0] rd_data
);

  logic [LINE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

@@ rtl/core/mbd_average.sv @@
module mbd_average
  import mbd_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  logic              quad,
  input  logic              last_in,
  input  logic [LINE_W-1:0] sums,
  input  logic [LINE_W-1:0] above,
  output logic [CHAN_W-1:0] red_out,
  output logic [CHAN_W-1:0] green_out,
  output logic [CHAN_W-1:0] blue_out,
  output logic              last_pixel
);

  logic [CHAN_W-1:0] avg [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [SUM_W+1:0] quad_sum;
      logic [SUM_W:0]   pair_sum;
      quad_sum = (SUM_W + 2)'(sums[c*SUM_W +: SUM_W])
               + (SUM_W + 2)'(above[c*SUM_W +: SUM_W])
               + (SUM_W + 2)'(2);
      pair_sum = (SUM_W + 1)'(sums[c*SUM_W +: SUM_W]) + (SUM_W + 1)'(1);
      // round half up; results never exceed 255
      avg[c] = quad ? quad_sum[CHAN_W+1:2] : pair_sum[CHAN_W:1];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      red_out    <= avg[0];
      green_out  <= avg[1];
      blue_out   <= avg[2];
      last_pixel <= last_in;
    end
  end

endmodule

@@ dv/mipmap_box_downsample_top_tb.sv @@
module mipmap_box_downsample_top_tb;
  import mbd_pkg::*;

  localparam int LINE_DEPTH    = DEFAULT_MAX_WIDTH / 2;
  localparam int SETTLE_CYCLES = 6;     // lets line writes land
  localparam int STALL_LIMIT   = 2000;  // cycles with no item moving on either side
  localparam int RANDOM_ITEMS  = 600;
  localparam int GAP_PCT       = 18;

  typedef logic [2:0][CHAN_W-1:0] pixel_t;   // [0] red, [1] green, [2] blue
  typedef logic [2:0][SUM_W-1:0]  pair_sums_t;

  typedef struct packed {
    pixel_t chan;
    logic   last;
  } out_pixel_t;

  // Scoreboard: tracks the source raster position and the partial sums, and
  // queues every output pixel the next mip level should contain.
  class mip_level_sb;
    logic [LOG2_W-1:0] width_log2;
    logic [LOG2_W-1:0] height_log2;
    pair_sums_t        upper_row_sums [LINE_DEPTH];
    pixel_t            held;
    int unsigned       col;
    int unsigned       row;
    out_pixel_t        pending_pixels[$];
    int unsigned       errors;
    int unsigned       pixels_in;
    int unsigned       pixels_out;
    string             chan_name[3];

    function new();
      width_log2  = '0;
      height_log2 = '0;
      held        = '0;
      col         = 0;
      row         = 0;
      errors      = 0;
      pixels_in   = 0;
      pixels_out  = 0;
      chan_name   = '{"red_out", "green_out", "blue_out"};
    endfunction

    // width clamps to the log2 limit, then to what the line store can hold
    function int unsigned eff_width();
      int unsigned k;
      k = (width_log2 > LOG2_LIMIT) ? LOG2_LIMIT : width_log2;
      while (k > 0 && (1 << k) > DEFAULT_MAX_WIDTH) k--;
      return 1 << k;
    endfunction

    function int unsigned eff_height();
      return 1 << ((height_log2 > LOG2_LIMIT) ? LOG2_LIMIT : height_log2);
    endfunction

    // any register write restarts the frame
    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [LOG2_W-1:0] val);
      if (idx == REG_WIDTH_LOG2) width_log2 = val;
      else height_log2 = val;
      col = 0;
      row = 0;
    endfunction

    function void take_source_pixel(pixel_t px);
      int unsigned w;
      int unsigned h;
      int unsigned slot;
      mode_t       mode;
      pair_sums_t  sums;
      out_pixel_t  res;
      logic        emit;
      w = eff_width();
      h = eff_height();
      pixels_in++;
      if (col >= w) col = 0;
      if (row >= h) row = 0;
      if (w == 1 && h == 1) mode = MODE_PASS;
      else if (w == 1) mode = MODE_VPAIR;
      else if (h == 1) mode = MODE_HPAIR;
      else mode = MODE_QUAD;
      emit     = 1'b0;
      res      = '0;
      res.last = (col == w - 1) && (row == h - 1);
      case (mode)
        MODE_PASS: begin
          res.chan = px;
          emit     = 1'b1;
        end
        MODE_VPAIR, MODE_HPAIR: begin
          if (((mode == MODE_VPAIR) ? row[0] : col[0]) == 1'b0) begin
            held = px;
          end else begin
            for (int c = 0; c < 3; c++)
              res.chan[c] = CHAN_W'((held[c] + px[c] + 1) >> 1);
            emit = 1'b1;
          end
        end
        default: begin
          if (!col[0]) begin
            held = px;
          end else begin
            slot = col >> 1;
            for (int c = 0; c < 3; c++) sums[c] = held[c] + px[c];
            if (slot < LINE_DEPTH) begin
              if (!row[0]) begin
                upper_row_sums[slot] = sums;
              end else begin
                for (int c = 0; c < 3; c++)
                  res.chan[c] = CHAN_W'((upper_row_sums[slot][c] + sums[c] + 2) >> 2);
                emit = 1'b1;
              end
            end
          end
        end
      endcase
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
      if (emit) pending_pixels.push_back(res);
    endfunction

    function void check_output_pixel(pixel_t got, logic got_last);
      out_pixel_t want;
      if (pending_pixels.size() == 0) begin
        $error("output pixel %h with no source block pending", got);
        errors++;
        return;
      end
      want = pending_pixels.pop_front();
      pixels_out++;
      for (int c = 0; c < 3; c++) begin
        if (got[c] !== want.chan[c]) begin
          $error("%s: expected %0d, got %0d", chan_name[c], want.chan[c], got[c]);
          errors++;
        end
      end
      if (got_last !== want.last) begin
        $error("last_pixel: expected %0d, got %0d", want.last, got_last);
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT pins; every input known from time zero
  // ---------------------------------------------------------------------------
  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [LOG2_W-1:0]      cfg_data  = '0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  logic [CHAN_W-1:0]      red_in    = '0;
  logic [CHAN_W-1:0]      green_in  = '0;
  logic [CHAN_W-1:0]      blue_in   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [CHAN_W-1:0]      red_out;
  logic [CHAN_W-1:0]      green_out;
  logic [CHAN_W-1:0]      blue_out;
  logic                   last_pixel;

  // random idling on both sides while set; cleared for a stretch with none
  bit          gaps_on      = 1'b1;
  int unsigned idle_cycles  = 0;
  int unsigned settings_run = 0;

  mip_level_sb sb = new();

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  mipmap_box_downsample_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .red_in     (red_in),
    .green_in   (green_in),
    .blue_in    (blue_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .last_pixel (last_pixel)
  );

  // Output side backpressure, changed only at the falling edge.
  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < GAP_PCT);
  end

  // Handshake monitor at the rising edge: a source item feeds the predictor,
  // an output item is checked against the oldest pending pixel. The watchdog
  // counts cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) sb.take_source_pixel({blue_in, green_in, red_in});
      if (out_valid && !out_stall)
        sb.check_output_pixel({blue_out, green_out, red_out}, last_pixel);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("Some tests failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers (entered and left at a falling edge)
  // ---------------------------------------------------------------------------

  // One source item; valid stays high into the next call unless a gap is drawn.
  task automatic send_pixel(input pixel_t px);
    while (gaps_on && $urandom_range(99) < GAP_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    red_in   <= px[0];
    green_in <= px[1];
    blue_in  <= px[2];
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  // Stop the source, wait out every pending pixel, then give the pipe time to
  // finish line-store writes from items that produce nothing.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [LOG2_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // which: 0 width only, 1 height only, otherwise both
  task automatic set_size(input logic [LOG2_W-1:0] wl, input logic [LOG2_W-1:0] hl,
                          input int which);
    settle();
    if (which != 1) write_reg(REG_WIDTH_LOG2, wl);
    if (which != 0) write_reg(REG_HEIGHT_LOG2, hl);
    settings_run++;
  endtask

  // channel values lean on the rails now and then
  function automatic pixel_t rand_pixel();
    pixel_t p;
    for (int c = 0; c < 3; c++) begin
      case ($urandom_range(9))
        0:       p[c] = '0;
        1:       p[c] = '1;
        default: p[c] = CHAN_W'($urandom_range(255));
      endcase
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned rand_items;
    int unsigned frame;
    int unsigned n;
    rand_items = 0;

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // 1x1 source: pass-through, every pixel is the last one
    set_size(4'd0, 4'd0, 2);
    send_pixel({8'h00, 8'h00, 8'h00});
    send_pixel({8'hff, 8'hff, 8'hff});
    send_pixel({8'h0f, 8'haa, 8'h55});
    send_pixel({8'hf0, 8'h55, 8'haa});

    // one pixel wide: vertical pair, rounding half up on the odd sum
    set_size(4'd0, 4'd1, 1);
    send_pixel({8'h01, 8'hff, 8'h00});
    send_pixel({8'h00, 8'hff, 8'h01});

    // one row high: horizontal pair
    set_size(4'd1, 4'd0, 2);
    send_pixel({8'h80, 8'h00, 8'hfe});
    send_pixel({8'h7f, 8'h01, 8'hff});

    // 2x2 box, two frames back to back; rails and round-half cases
    set_size(4'd1, 4'd1, 1);
    send_pixel({8'h00, 8'h00, 8'hff});
    send_pixel({8'h01, 8'h00, 8'hff});
    send_pixel({8'h00, 8'h00, 8'hff});
    send_pixel({8'h01, 8'h00, 8'hff});
    send_pixel({8'h02, 8'h01, 8'h00});
    send_pixel({8'h03, 8'h02, 8'h00});
    send_pixel({8'h00, 8'h03, 8'h01});
    send_pixel({8'h01, 8'h03, 8'h00});

    // Wide source: a 128x2 frame fills 64 line-store slots and reads them back.
    set_size(4'd7, 4'd1, 2);
    repeat (256) send_pixel(rand_pixel());

    // Tall source: one column of 128 rows; the last flag lands on the final pair.
    set_size(4'd0, 4'd7, 2);
    repeat (128) send_pixel(rand_pixel());

    // Random phases: mostly small shapes sent as whole frames, some cut off
    // mid-frame by the next register write, now and then a huge shape.
    while (rand_items < RANDOM_ITEMS) begin
      settle();
      gaps_on = (settings_run % 20 == 8) ? 1'b0 : ($urandom_range(9) != 0);
      if ($urandom_range(99) < 85)
        set_size(LOG2_W'($urandom_range(4)), LOG2_W'($urandom_range(4)),
                 $urandom_range(3));
      else
        set_size(LOG2_W'($urandom_range(15)), LOG2_W'($urandom_range(15)),
                 $urandom_range(3));
      frame = sb.eff_width() * sb.eff_height();
      if (frame <= 256 && $urandom_range(99) < 70)
        n = frame * $urandom_range(1, 3);
      else
        n = $urandom_range(1, (frame < 200) ? frame : 200);
      repeat (n) send_pixel(rand_pixel());
      rand_items += n;
    end

    settle();
    $display("Covered %0d source items and %0d output pixels over %0d size settings,",
             sb.pixels_in, sb.pixels_out, settings_run);
    $display("including all four shapes, clamped size codes and frames cut off mid-way.");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
